// ----- design/drps_pkg.sv -----
// ----------------------------------------------------------------------------
// Deck recut pass sequencer package
// Shared types, constants, command/status structs and the CORDIC atan table.
// ----------------------------------------------------------------------------
package drps_pkg;

  localparam int MaxPasses    = 6;
  localparam int ReachTolMm   = 30;
  localparam int MinSegmentMm = 100;
  localparam int CordicSteps  = 15;

  typedef enum logic [1:0] {
    PH_REVERSE = 2'd0,
    PH_DWELL   = 2'd1,
    PH_PASS    = 2'd2,
    PH_SPARE   = 2'd3
  } phase_t;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_GAVE  = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  localparam logic [2:0] CFG_CREEP  = 3'd0;
  localparam logic [2:0] CFG_PASS   = 3'd1;
  localparam logic [2:0] CFG_MAXWS  = 3'd2;
  localparam logic [2:0] CFG_GAIN   = 3'd3;
  localparam logic [2:0] CFG_MAXCUR = 3'd4;
  localparam logic [2:0] CFG_MAXH   = 3'd5;
  localparam logic [2:0] CFG_HSTEP  = 3'd6;
  localparam logic [2:0] CFG_DWELL  = 3'd7;

  typedef struct packed {
    logic cordic_start;
    logic enter_commit;
    logic prog_start;
    logic tick_eval;
    logic drive_start;
    logic out_load;
  } drps_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic prog_done;
    logic drive_done;
    logic need_drive;
  } drps_sts_t;

  function automatic logic [15:0] atan_lut(input logic [3:0] i);
    logic [15:0] r;
    unique case (i)
      4'd0: r = 16'd8192;  4'd1: r = 16'd4836; 4'd2: r = 16'd2555;
      4'd3: r = 16'd1297;  4'd4: r = 16'd651;  4'd5: r = 16'd326;
      4'd6: r = 16'd163;   4'd7: r = 16'd81;   4'd8: r = 16'd41;
      4'd9: r = 16'd20;    4'd10: r = 16'd10;  4'd11: r = 16'd5;
      4'd12: r = 16'd3;    4'd13: r = 16'd1;   4'd14: r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/deck_recut_pass_sequencer.sv -----
// An enter beat runs a 15-step CORDIC and two trig products, a driving tick
// seven products on one shared 20x20 multiplier; a stopped tick skips the
// drive products and a blade fault tick goes straight to the result.
// Throughput: one beat at a time; the next beat is taken once the result is
// registered, so a stalled result holds off the input. Reset is
// synchronous, active low, and restores register defaults and dwell phase.
// ----------------------------------------------------------------------------
// Deck recut pass sequencer
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module deck_recut_pass_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic signed [19:0] in_pos_x,
  input  logic signed [19:0] in_pos_y,
  input  logic signed [15:0] in_heading,
  input  logic [31:0]        in_now_ms,
  input  logic               in_blade_fault,
  input  logic [7:0]         in_desired_height,
  input  logic [11:0]        in_backup_distance,
  input  logic [8:0]         in_forward_extent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_left_current,
  output logic signed [17:0] out_right_current,
  output logic               out_drive_update,
  output logic [7:0]         out_deck_height,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import drps_pkg::*;

  drps_cmd_t cmd;
  drps_sts_t sts;

  assign cfg_ready = 1'b1;

  drps_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_blade_fault,
    .out_valid, .out_ready, .cmd, .sts
  );

  drps_datapath u_dp (
    .clk, .rst_n,
    .in_accept(in_valid && in_ready),
    .in_mode, .in_pos_x, .in_pos_y, .in_heading, .in_now_ms, .in_blade_fault,
    .in_desired_height, .in_backup_distance, .in_forward_extent,
    .cfg_wr(cfg_valid), .cfg_index, .cfg_data, .cmd, .sts,
    .out_left_current, .out_right_current, .out_drive_update,
    .out_deck_height, .out_status
  );
endmodule

// ----- design/drps_ctrl.sv -----
// ----------------------------------------------------------------------------
// Deck recut pass sequencer controller
// Sequences the enter and tick work through the datapath one beat at a time.
// ----------------------------------------------------------------------------
module drps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic                in_blade_fault,
  output logic                out_valid,
  input  logic                out_ready,
  output drps_pkg::drps_cmd_t cmd,
  input  drps_pkg::drps_sts_t sts
);
  import drps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CORDIC, S_COMMIT, S_PROG, S_EVAL, S_DRIVE, S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   mode_r, mode_nxt;

  logic out_free;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode;
          if (!in_mode) begin
            cmd.cordic_start = 1'b1;
            state_nxt = S_CORDIC;
          end else if (in_blade_fault) begin
            state_nxt = S_LOAD;
          end else begin
            cmd.prog_start = 1'b1;
            state_nxt = S_PROG;
          end
        end
      end
      S_CORDIC: if (sts.cordic_done) state_nxt = S_COMMIT;
      S_COMMIT: begin
        cmd.enter_commit = 1'b1;
        state_nxt = S_LOAD;
      end
      S_PROG: if (sts.prog_done) state_nxt = S_EVAL;
      S_EVAL: begin
        cmd.tick_eval = 1'b1;
        if (sts.need_drive) begin
          cmd.drive_start = 1'b1;
          state_nxt = S_DRIVE;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_DRIVE: if (sts.drive_done) state_nxt = S_LOAD;
      S_LOAD: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free) else $error("result overwritten");
  a_busy_noready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r) else $error("valid missing");
  a_commit_enter: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enter_commit |-> !mode_r) else $error("commit on tick");
`endif
endmodule

// ----- design/drps_datapath.sv -----
// ----------------------------------------------------------------------------
// Deck recut pass sequencer datapath
// Holds recovery state, a CORDIC, a shared multiplier and the result register.
// ----------------------------------------------------------------------------
module drps_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic                in_mode,
  input  logic signed [19:0]  in_pos_x,
  input  logic signed [19:0]  in_pos_y,
  input  logic signed [15:0]  in_heading,
  input  logic [31:0]         in_now_ms,
  input  logic                in_blade_fault,
  input  logic [7:0]          in_desired_height,
  input  logic [11:0]         in_backup_distance,
  input  logic [8:0]          in_forward_extent,
  input  logic                cfg_wr,
  input  logic [2:0]          cfg_index,
  input  logic [16:0]         cfg_data,
  input  drps_pkg::drps_cmd_t cmd,
  output drps_pkg::drps_sts_t sts,
  output logic signed [17:0]  out_left_current,
  output logic signed [17:0]  out_right_current,
  output logic                out_drive_update,
  output logic [7:0]          out_deck_height,
  output logic [1:0]          out_status
);
  import drps_pkg::*;

  // configuration
  logic [10:0] creep_r, pspeed_r;
  logic [11:0] maxws_r;
  logic [15:0] gain_r, dwell_r;
  logic [16:0] maxcur_r;
  logic [7:0]  maxh_r, hstep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      creep_r <= 11'd100; pspeed_r <= 11'd300; maxws_r <= 12'd1000;
      gain_r <= 16'd2560; maxcur_r <= 17'd10000; maxh_r <= 8'd80;
      hstep_r <= 8'd10; dwell_r <= 16'd500;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_CREEP:  creep_r  <= cfg_data[10:0];
        CFG_PASS:   pspeed_r <= cfg_data[10:0];
        CFG_MAXWS:  maxws_r  <= cfg_data[11:0];
        CFG_GAIN:   gain_r   <= cfg_data[15:0];
        CFG_MAXCUR: maxcur_r <= cfg_data;
        CFG_MAXH:   maxh_r   <= cfg_data[7:0];
        CFG_HSTEP:  hstep_r  <= cfg_data[7:0];
        CFG_DWELL:  dwell_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic signed [19:0] px_r, py_r;
  logic signed [15:0] hd_r;
  logic [31:0] now_r;
  logic [7:0]  des_r;
  logic [11:0] bk_r;
  logic [8:0]  fw_r;
  always_ff @(posedge clk) begin
    if (in_accept) begin
      px_r <= in_pos_x; py_r <= in_pos_y; hd_r <= in_heading;
      now_r <= in_now_ms; des_r <= in_desired_height;
      bk_r <= in_backup_distance; fw_r <= in_forward_extent;
    end
  end

  // recovery state
  logic signed [19:0] back_x_r, back_y_r;
  logic signed [15:0] ent_hd_r, sin_r, cos_r;
  logic [12:0] seg_r;
  logic [7:0]  tgt_r, pass_h_r;
  logic [3:0]  passes_r;
  phase_t      phase_r;
  logic        fwd_r, boxed_r;
  logic [31:0] dwell_st_r;

  // CORDIC, one step a cycle
  logic signed [17:0] cx_r, cy_r, cz_r;
  logic [3:0] ci_r;
  logic       cbusy_r, cneg_r, cdone_r, cdone_d_r;
  logic signed [17:0] cxs, cys, cz0;
  logic [15:0] atv;
  assign cxs = cx_r >>> ci_r;
  assign cys = cy_r >>> ci_r;
  assign atv = atan_lut(ci_r);
  assign cz0 = 18'(in_heading);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbusy_r <= 1'b0; cdone_r <= 1'b0; cdone_d_r <= 1'b0;
    end else begin
      cdone_r   <= !cmd.cordic_start && cbusy_r && (ci_r == 4'(CordicSteps - 1));
      cdone_d_r <= cdone_r;
      if (cmd.cordic_start) begin
        cbusy_r <= 1'b1; ci_r <= '0; cx_r <= 18'sd9949; cy_r <= '0;
        if (cz0 > 18'sd16384) begin
          cz_r <= cz0 - 18'sd32768; cneg_r <= 1'b1;
        end else if (cz0 < -18'sd16384) begin
          cz_r <= cz0 + 18'sd32768; cneg_r <= 1'b1;
        end else begin
          cz_r <= cz0; cneg_r <= 1'b0;
        end
      end else if (cbusy_r) begin
        if (!cz_r[17]) begin
          cx_r <= cx_r - cys; cy_r <= cy_r + cxs; cz_r <= cz_r - 18'(atv);
        end else begin
          cx_r <= cx_r + cys; cy_r <= cy_r - cxs; cz_r <= cz_r + 18'(atv);
        end
        if (ci_r == 4'(CordicSteps - 1)) cbusy_r <= 1'b0;
        ci_r <= ci_r + 4'd1;
      end
    end
  end

  logic signed [17:0] cxf, cyf;
  logic signed [15:0] cos_v, sin_v;
  assign cxf = cneg_r ? -cx_r : cx_r;
  assign cyf = cneg_r ? -cy_r : cy_r;
  assign cos_v = (cxf > 18'sd16384) ? 16'sd16384 :
                 (cxf < -18'sd16384) ? -16'sd16384 : 16'(cxf);
  assign sin_v = (cyf > 18'sd16384) ? 16'sd16384 :
                 (cyf < -18'sd16384) ? -16'sd16384 : 16'(cyf);

  // shared multiplier: 20x20 signed
  logic signed [19:0] ma, mb;
  logic signed [39:0] mp_r;
  always_ff @(posedge clk) mp_r <= ma * mb;

  function automatic logic signed [39:0] rshr(input logic signed [39:0] v,
                                              input int s);
    logic signed [39:0] a, r;
    a = v[39] ? -v : v;
    r = (a + (40'sd1 <<< (s - 1))) >>> s;
    return v[39] ? -r : r;
  endfunction

  // progress: two products summed
  logic [2:0] pstep_r;
  logic       pbusy_r, pdone_r;
  logic signed [37:0] prog_r;
  logic signed [19:0] dx, dy;
  assign dx = px_r - back_x_r;
  assign dy = py_r - back_y_r;

  // drive sequencer
  logic [3:0] dstep_r;
  logic       dbusy_r, ddone_r;
  logic signed [12:0] v_r;
  logic signed [17:0] h_r, h_v;
  logic signed [19:0] wl_r, wr_r;
  logic signed [17:0] lc_r, rc_r;
  logic signed [15:0] dh;
  assign dh = ent_hd_r - hd_r;
  assign h_v = 18'(rshr(mp_r, 14));

  // enter commit products
  logic signed [39:0] ebx_r;

  always_comb begin
    ma = '0; mb = '0;
    if (cdone_r || cdone_d_r) begin
      ma = 20'(bk_r);
      mb = cdone_r ? 20'(sin_v) : 20'(cos_r);
    end else if (pbusy_r) begin
      ma = (pstep_r == 3'd0) ? dx : dy;
      mb = (pstep_r == 3'd0) ? 20'(sin_r) : 20'(cos_r);
    end else if (dbusy_r) begin
      unique case (dstep_r)
        4'd0: begin ma = 20'(dh); mb = 20'sd25736; end
        4'd1: begin ma = 20'(v_r); mb = 20'sd32768 - 20'(h_v); end
        4'd2: begin ma = 20'(v_r); mb = 20'sd32768 + 20'(h_r); end
        4'd3: begin ma = wl_r; mb = 20'($signed({1'b0, gain_r})); end
        4'd4: begin ma = wr_r; mb = 20'($signed({1'b0, gain_r})); end
        default: ;
      endcase
    end
  end

  function automatic logic signed [19:0] wclamp(input logic signed [39:0] v,
                                                input logic [11:0] lim);
    logic signed [39:0] l;
    l = 40'($signed({1'b0, lim}));
    if (v > l) return 20'(l);
    if (v < -l) return 20'(-l);
    return 20'(v);
  endfunction

  function automatic logic signed [17:0] cclamp(input logic signed [39:0] p,
                                                input logic [16:0] lim);
    logic signed [39:0] a, l;
    a = p[39] ? -((-p) >>> 8) : (p >>> 8);
    l = 40'($signed({1'b0, lim}));
    if (a > l) return 18'(l);
    if (a < -l) return 18'(-l);
    return 18'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pbusy_r <= 1'b0; pdone_r <= 1'b0; dbusy_r <= 1'b0; ddone_r <= 1'b0;
      sin_r <= '0; cos_r <= '0;
    end else begin
      pdone_r <= !cmd.prog_start && pbusy_r && (pstep_r == 3'd2);
      ddone_r <= !cmd.drive_start && dbusy_r && (dstep_r == 4'd5);
      if (cdone_r) begin
        sin_r <= sin_v; cos_r <= cos_v;
      end
      if (cdone_d_r) ebx_r <= mp_r;
      if (cmd.prog_start) begin
        pbusy_r <= 1'b1; pstep_r <= '0;
      end else if (pbusy_r) begin
        pstep_r <= pstep_r + 3'd1;
        if (pstep_r == 3'd1) prog_r <= 38'(mp_r);
        if (pstep_r == 3'd2) begin
          prog_r <= prog_r + 38'(mp_r); pbusy_r <= 1'b0;
        end
      end
      if (cmd.drive_start) begin
        dbusy_r <= 1'b1; dstep_r <= '0;
      end else if (dbusy_r) begin
        dstep_r <= dstep_r + 4'd1;
        unique case (dstep_r)
          4'd1: h_r <= h_v;
          4'd2: wl_r <= wclamp(rshr(mp_r, 15), maxws_r);
          4'd3: wr_r <= wclamp(rshr(mp_r, 15), maxws_r);
          4'd4: lc_r <= cclamp(mp_r, maxcur_r);
          4'd5: begin
            rc_r <= cclamp(mp_r, maxcur_r); dbusy_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // swap for reverse: v<0 uses (32768+h) for left
  logic signed [12:0] v_sel;
  logic signed [37:0] tol, fend;
  logic rev_reach, fwd_reach, bwd_reach, dw_over;
  assign tol  = 38'sd30 <<< 14;
  assign fend = (38'($signed({1'b0, seg_r})) - 38'sd30) <<< 14;
  assign rev_reach = (prog_r <= tol);
  assign fwd_reach = (prog_r >= fend);
  assign bwd_reach = rev_reach;
  assign dw_over = ((now_r - dwell_st_r) >= {16'd0, dwell_r});

  always_comb begin
    sts.cordic_done = cdone_d_r;
    sts.prog_done   = pdone_r;
    sts.drive_done  = ddone_r;
    sts.need_drive  = 1'b0;
    if (!boxed_r) begin
      if (phase_r == PH_REVERSE) sts.need_drive = !rev_reach;
      else if (phase_r == PH_PASS) sts.need_drive = fwd_r ? !fwd_reach : !bwd_reach;
    end
    unique case (phase_r)
      PH_REVERSE: v_sel = -13'($signed({1'b0, creep_r}));
      default: v_sel = fwd_r ? 13'($signed({1'b0, pspeed_r}))
                             : -13'($signed({1'b0, pspeed_r}));
    endcase
  end

  // result staging
  logic [1:0] st_r;
  logic [7:0] dk_r;
  logic       upd_r, drv_r;
  logic [3:0] pinc;
  logic [12:0] seg_v;
  logic [8:0] th_sum;
  assign pinc  = (passes_r == 4'd15) ? passes_r : passes_r + 4'd1;
  assign seg_v = 13'(bk_r) + 13'(fw_r);
  assign th_sum = 9'(tgt_r) + 9'(hstep_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_x_r <= '0; back_y_r <= '0; ent_hd_r <= '0; seg_r <= '0;
      tgt_r <= '0; pass_h_r <= '0; passes_r <= '0; phase_r <= PH_DWELL;
      fwd_r <= 1'b1; dwell_st_r <= '0; boxed_r <= 1'b0;
      st_r <= ST_BUSY; dk_r <= '0; upd_r <= 1'b0; drv_r <= 1'b0;
    end else begin
      if (in_accept) begin
        upd_r <= in_mode; drv_r <= 1'b0;
        if (in_mode && !in_blade_fault && boxed_r) begin
          st_r <= ST_GAVE; dk_r <= tgt_r;
        end else begin
          st_r <= (in_mode && in_blade_fault) ? ST_FAULT : ST_BUSY;
          dk_r <= pass_h_r;
        end
      end
      if (cmd.enter_commit) begin
        ent_hd_r <= hd_r; tgt_r <= des_r;
        back_x_r <= px_r - 20'(rshr(ebx_r, 14));
        back_y_r <= py_r - 20'(rshr(mp_r, 14));
        seg_r <= seg_v; pass_h_r <= maxh_r; passes_r <= '0; fwd_r <= 1'b1;
        boxed_r <= (seg_v < 13'(MinSegmentMm));
        if (bk_r > 12'(ReachTolMm)) phase_r <= PH_REVERSE;
        else begin
          phase_r <= PH_DWELL; dwell_st_r <= now_r;
        end
        dk_r <= maxh_r;
      end
      if (cmd.tick_eval && !boxed_r) begin
        v_r <= v_sel;
        drv_r <= sts.need_drive;
        priority case (phase_r)
          PH_REVERSE: if (rev_reach) begin
            phase_r <= PH_DWELL; dwell_st_r <= now_r;
          end
          PH_PASS: if (!sts.need_drive) begin
            passes_r <= pinc;
            if (pass_h_r <= tgt_r) begin
              dk_r <= tgt_r; st_r <= ST_DONE;
            end else if (pinc >= 4'(MaxPasses)) begin
              dk_r <= tgt_r; st_r <= ST_GAVE;
            end else begin
              if (9'(pass_h_r) < th_sum) begin
                pass_h_r <= tgt_r; dk_r <= tgt_r;
              end else begin
                pass_h_r <= pass_h_r - hstep_r; dk_r <= pass_h_r - hstep_r;
              end
              fwd_r <= !fwd_r; phase_r <= PH_DWELL; dwell_st_r <= now_r;
            end
          end
          default: if (dw_over) phase_r <= PH_PASS;
        endcase
      end
    end
  end

  // swap left/right mapping for reverse: products 1 and 2 give (32768-h),(32768+h)
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_left_current  <= drv_r ? (v_r[12] ? rc_r : lc_r) : '0;
      out_right_current <= drv_r ? (v_r[12] ? lc_r : rc_r) : '0;
      out_drive_update  <= upd_r;
      out_deck_height   <= dk_r;
      out_status        <= st_r;
    end
  end

`ifndef ASSERT_OFF
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pbusy_r && dbusy_r)) else $error("multiplier contention");
  a_cdone: assert property (@(posedge clk) disable iff (!rst_n)
    cdone_r |-> $past(cbusy_r)) else $error("spurious cordic done");
  a_pass_h: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_eval && !boxed_r && phase_r == PH_PASS |=> pass_h_r <= $past(pass_h_r))
    else $error("height rose");
`endif
endmodule
